>>> hdl/line_rect_clip_crossings_core_macros.svh
// Assertion macros for the line clipper checker.
// Included by the checker file only; no other dependencies.
`ifndef LINE_RECT_CLIP_CROSSINGS_CORE_MACROS_SVH
`define LINE_RECT_CLIP_CROSSINGS_CORE_MACROS_SVH

// Same-cycle implication
`define LRCC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define LRCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/lrcc_pkg.sv
// Shared types, codes and the outcode function for the line clipper.
// No dependencies.
package lrcc_pkg;

   // Widest supported coordinate, used for the common outcode compare
   localparam int MAX_COORD_WIDTH = 32;

   // Outcode bit positions
   localparam int OC_LEFT   = 0;
   localparam int OC_RIGHT  = 1;
   localparam int OC_TOP    = 2;
   localparam int OC_BOTTOM = 3;

   localparam int MAX_ROUNDS = 4;

   typedef logic [3:0] outcode_type;
   typedef logic [1:0] edge_type;
   typedef logic [1:0] status_type;
   typedef logic [1:0] csr_index_type;
   typedef logic [2:0] round_type;
   typedef logic signed [MAX_COORD_WIDTH-1:0] wide_coord_type;

   localparam edge_type EDGE_LEFT   = 2'd0;
   localparam edge_type EDGE_RIGHT  = 2'd1;
   localparam edge_type EDGE_BOTTOM = 2'd2;
   localparam edge_type EDGE_TOP    = 2'd3;

   localparam status_type STATUS_REJECT = 2'd0;
   localparam status_type STATUS_CROSS  = 2'd1;
   localparam status_type STATUS_INSIDE = 2'd2;

   localparam csr_index_type CSR_CLIP_LEFT   = 2'd0;
   localparam csr_index_type CSR_CLIP_TOP    = 2'd1;
   localparam csr_index_type CSR_CLIP_RIGHT  = 2'd2;
   localparam csr_index_type CSR_CLIP_BOTTOM = 2'd3;

   // Cohen-Sutherland outcode of one point against the inclusive rectangle
   function automatic outcode_type calc_outcode(
      input wide_coord_type x,
      input wide_coord_type y,
      input wide_coord_type left,
      input wide_coord_type top,
      input wide_coord_type right,
      input wide_coord_type bottom
   );
      outcode_type oc;
      oc            = '0;
      oc[OC_LEFT]   = (x < left);
      oc[OC_RIGHT]  = (x > right);
      oc[OC_TOP]    = (y < top);
      oc[OC_BOTTOM] = (y > bottom);
      return oc;
   endfunction

endpackage

>>> hdl/lrcc_front.sv
// Front end: accepts segments, computes both outcodes, holds a two-entry queue.
// Depends on lrcc_pkg.
module lrcc_front #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_begin_x,
   input  logic signed [COORD_WIDTH-1:0] req_begin_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   input  logic signed [COORD_WIDTH-1:0] clip_left,
   input  logic signed [COORD_WIDTH-1:0] clip_top,
   input  logic signed [COORD_WIDTH-1:0] clip_right,
   input  logic signed [COORD_WIDTH-1:0] clip_bottom,
   output logic                          q_valid,
   input  logic                          q_pop,
   output logic signed [COORD_WIDTH-1:0] q_bx,
   output logic signed [COORD_WIDTH-1:0] q_by,
   output logic signed [COORD_WIDTH-1:0] q_ex,
   output logic signed [COORD_WIDTH-1:0] q_ey,
   output lrcc_pkg::outcode_type         q_bc,
   output lrcc_pkg::outcode_type         q_ec
);
   import lrcc_pkg::*;

   localparam int DEPTH = 2;

   logic signed [COORD_WIDTH-1:0] bx_ff [DEPTH];
   logic signed [COORD_WIDTH-1:0] by_ff [DEPTH];
   logic signed [COORD_WIDTH-1:0] ex_ff [DEPTH];
   logic signed [COORD_WIDTH-1:0] ey_ff [DEPTH];
   outcode_type                   bc_ff [DEPTH];
   outcode_type                   ec_ff [DEPTH];

   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;
   outcode_type bc_new, ec_new;

   // Classify the incoming segment
   assign bc_new = calc_outcode(wide_coord_type'(req_begin_x), wide_coord_type'(req_begin_y),
                                wide_coord_type'(clip_left), wide_coord_type'(clip_top),
                                wide_coord_type'(clip_right), wide_coord_type'(clip_bottom));
   assign ec_new = calc_outcode(wide_coord_type'(req_end_x), wide_coord_type'(req_end_y),
                                wide_coord_type'(clip_left), wide_coord_type'(clip_top),
                                wide_coord_type'(clip_right), wide_coord_type'(clip_bottom));

   assign req_ready = (count_ff != 2'(DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_pop && q_valid;

   // Queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         bx_ff[wr_ptr_ff] <= req_begin_x;
         by_ff[wr_ptr_ff] <= req_begin_y;
         ex_ff[wr_ptr_ff] <= req_end_x;
         ey_ff[wr_ptr_ff] <= req_end_y;
         bc_ff[wr_ptr_ff] <= bc_new;
         ec_ff[wr_ptr_ff] <= ec_new;
      end
   end

   assign q_bx = bx_ff[rd_ptr_ff];
   assign q_by = by_ff[rd_ptr_ff];
   assign q_ex = ex_ff[rd_ptr_ff];
   assign q_ey = ey_ff[rd_ptr_ff];
   assign q_bc = bc_ff[rd_ptr_ff];
   assign q_ec = ec_ff[rd_ptr_ff];

endmodule

>>> hdl/lrcc_divider.sv
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// No package dependencies.
module lrcc_divider #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [2*COORD_WIDTH-1:0]   dividend,
   input  logic [COORD_WIDTH-1:0]     divisor,
   output logic                       done,
   output logic [2*COORD_WIDTH-1:0]   quotient
);
   localparam int W  = COORD_WIDTH;
   localparam int DW = 2 * COORD_WIDTH;
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] dq_ff, dq_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic          fits;

   // One restoring step
   assign trial = {rem_ff, dq_ff[DW-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         dq_in  = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = CW'(DW);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? W'(trial - {1'b0, div_ff}) : W'(trial);
         dq_in   = {dq_ff[DW-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

>>> hdl/lrcc_engine.sv
// Back end: runs the clip rounds on one segment and drives the result register.
// Depends on lrcc_pkg and lrcc_divider.
module lrcc_engine #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [COORD_WIDTH-1:0] clip_left,
   input  logic signed [COORD_WIDTH-1:0] clip_top,
   input  logic signed [COORD_WIDTH-1:0] clip_right,
   input  logic signed [COORD_WIDTH-1:0] clip_bottom,
   input  logic                          q_valid,
   output logic                          q_pop,
   input  logic signed [COORD_WIDTH-1:0] q_bx,
   input  logic signed [COORD_WIDTH-1:0] q_by,
   input  logic signed [COORD_WIDTH-1:0] q_ex,
   input  logic signed [COORD_WIDTH-1:0] q_ey,
   input  lrcc_pkg::outcode_type         q_bc,
   input  lrcc_pkg::outcode_type         q_ec,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_has_point,
   output lrcc_pkg::edge_type            rsp_edge_res,
   output logic signed [COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [COORD_WIDTH-1:0] rsp_point_y,
   output lrcc_pkg::status_type          rsp_status,
   output logic                          rsp_last
);
   import lrcc_pkg::*;

   localparam int W = COORD_WIDTH;
   localparam int S = 2 * COORD_WIDTH + 2;
   localparam logic signed [S-1:0] SAT_HI = {{(W+3){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [S-1:0] SAT_LO = {{(W+3){1'b1}}, {(W-1){1'b0}}};

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CHECK  = 4'd1;
   localparam logic [3:0] ST_HSEL   = 4'd2;
   localparam logic [3:0] ST_VSEL   = 4'd3;
   localparam logic [3:0] ST_MUL    = 4'd4;
   localparam logic [3:0] ST_DSTART = 4'd5;
   localparam logic [3:0] ST_DIV    = 4'd6;
   localparam logic [3:0] ST_FIN    = 4'd7;
   localparam logic [3:0] ST_UPD    = 4'd8;
   localparam logic [3:0] ST_STAT   = 4'd9;

   logic [3:0]          state_ff, state_in;
   round_type           rounds_ff, rounds_in;
   status_type          status_ff, status_in;
   logic signed [W-1:0] bx_ff, bx_in, by_ff, by_in, ex_ff, ex_in, ey_ff, ey_in;
   outcode_type         bc_ff, bc_in, ec_ff, ec_in, cc_ff, cc_in;
   logic                onbeg_ff, onbeg_in;
   logic                vphase_ff, vphase_in;
   edge_type            edge_ff, edge_in;
   logic signed [W-1:0] edgev_ff, edgev_in;
   logic [W-1:0]        mag_a_ff, mag_a_in, mag_b_ff, mag_b_in, mag_c_ff, mag_c_in;
   logic                neg_ff, neg_in;
   logic [2*W-1:0]      prod_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_has_point_ff, rsp_has_point_in;
   edge_type            rsp_edge_ff, rsp_edge_in;
   logic signed [W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   logic signed [W-1:0] cur_x, cur_y, ev_h, ev_v, ev_sel, p_sel, nv;
   logic signed [W:0]   dx, dy, op_a, op_b, op_c;
   logic signed [S-1:0] q_ext, q_sgn, sum;
   logic                out_free;
   logic                div_start, div_done;
   logic [2*W-1:0]      quotient;
   outcode_type         oc_cur;

   function automatic logic [W-1:0] mag(input logic signed [W:0] v);
      logic signed [W:0] n;
      n = -v;
      return v[W] ? W'(n) : W'(v);
   endfunction

   // Selected endpoint and difference terms
   assign cur_x  = onbeg_ff ? bx_ff : ex_ff;
   assign cur_y  = onbeg_ff ? by_ff : ey_ff;
   assign dx     = (W+1)'(bx_ff) - (W+1)'(ex_ff);
   assign dy     = (W+1)'(by_ff) - (W+1)'(ey_ff);
   assign ev_h   = cc_ff[OC_LEFT] ? clip_left : clip_right;
   assign ev_v   = cc_ff[OC_BOTTOM] ? clip_bottom : clip_top;
   assign ev_sel = (state_ff == ST_VSEL) ? ev_v : ev_h;
   assign op_a   = (state_ff == ST_VSEL) ? dx : dy;
   assign op_c   = (state_ff == ST_VSEL) ? dy : dx;
   assign op_b   = (state_ff == ST_VSEL) ? ((W+1)'(ev_v) - (W+1)'(cur_y))
                                         : ((W+1)'(ev_h) - (W+1)'(cur_x));

   assign oc_cur = calc_outcode(wide_coord_type'(cur_x), wide_coord_type'(cur_y),
                                wide_coord_type'(clip_left), wide_coord_type'(clip_top),
                                wide_coord_type'(clip_right), wide_coord_type'(clip_bottom));

   // Interpolated coordinate with saturation
   assign p_sel = vphase_ff ? cur_x : cur_y;
   assign q_ext = {2'b00, quotient};
   assign q_sgn = neg_ff ? -q_ext : q_ext;
   assign sum   = S'(p_sel) + q_sgn;
   assign nv    = (sum > SAT_HI) ? W'(SAT_HI) : ((sum < SAT_LO) ? W'(SAT_LO) : W'(sum));

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign div_start = (state_ff == ST_DSTART);

   lrcc_divider #(.COORD_WIDTH(COORD_WIDTH)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (mag_c_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      rounds_in        = rounds_ff;
      status_in        = status_ff;
      bx_in            = bx_ff;
      by_in            = by_ff;
      ex_in            = ex_ff;
      ey_in            = ey_ff;
      bc_in            = bc_ff;
      ec_in            = ec_ff;
      cc_in            = cc_ff;
      onbeg_in         = onbeg_ff;
      vphase_in        = vphase_ff;
      edge_in          = edge_ff;
      edgev_in         = edgev_ff;
      mag_a_in         = mag_a_ff;
      mag_b_in         = mag_b_ff;
      mag_c_in         = mag_c_ff;
      neg_in           = neg_ff;
      q_pop            = 1'b0;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_has_point_in = rsp_has_point_ff;
      rsp_edge_in      = rsp_edge_ff;
      rsp_x_in         = rsp_x_ff;
      rsp_y_in         = rsp_y_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_last_in      = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               bx_in     = q_bx;
               by_in     = q_by;
               ex_in     = q_ex;
               ey_in     = q_ey;
               bc_in     = q_bc;
               ec_in     = q_ec;
               rounds_in = '0;
               status_in = ((q_bc | q_ec) == '0) ? STATUS_INSIDE : STATUS_CROSS;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (bc_ff == '0 && ec_ff == '0) begin
               state_in = ST_STAT;
            end else if ((bc_ff & ec_ff) != '0 || rounds_ff == round_type'(MAX_ROUNDS)) begin
               status_in = STATUS_REJECT;
               state_in  = ST_STAT;
            end else begin
               onbeg_in  = (bc_ff != '0);
               cc_in     = (bc_ff != '0) ? bc_ff : ec_ff;
               rounds_in = rounds_ff + 1'b1;
               state_in  = ST_HSEL;
            end
         end
         ST_HSEL, ST_VSEL: begin
            vphase_in = (state_ff == ST_VSEL);
            edgev_in  = ev_sel;
            mag_a_in  = mag(op_a);
            mag_b_in  = mag(op_b);
            mag_c_in  = mag(op_c);
            neg_in    = op_a[W] ^ op_b[W] ^ op_c[W];
            if (state_ff == ST_HSEL) begin
               edge_in = cc_ff[OC_LEFT] ? EDGE_LEFT : EDGE_RIGHT;
               if (dx != '0 && (cc_ff[OC_LEFT] || cc_ff[OC_RIGHT])) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_VSEL;
               end
            end else begin
               edge_in = cc_ff[OC_BOTTOM] ? EDGE_BOTTOM : EDGE_TOP;
               if (dy != '0 && (cc_ff[OC_BOTTOM] || cc_ff[OC_TOP])) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_UPD;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_has_point_in = 1'b1;
               rsp_edge_in      = edge_ff;
               rsp_status_in    = STATUS_REJECT;
               rsp_last_in      = 1'b0;
               if (vphase_ff) begin
                  rsp_x_in = nv;
                  rsp_y_in = edgev_ff;
                  if (onbeg_ff) begin
                     bx_in = nv;
                     by_in = edgev_ff;
                  end else begin
                     ex_in = nv;
                     ey_in = edgev_ff;
                  end
                  state_in = ST_UPD;
               end else begin
                  rsp_x_in = edgev_ff;
                  rsp_y_in = nv;
                  if (onbeg_ff) begin
                     bx_in = edgev_ff;
                     by_in = nv;
                  end else begin
                     ex_in = edgev_ff;
                     ey_in = nv;
                  end
                  state_in = ST_VSEL;
               end
            end
         end
         ST_UPD: begin
            if (onbeg_ff) begin
               bc_in = oc_cur;
            end else begin
               ec_in = oc_cur;
            end
            state_in = ST_CHECK;
         end
         ST_STAT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_has_point_in = 1'b0;
               rsp_edge_in      = EDGE_LEFT;
               rsp_x_in         = '0;
               rsp_y_in         = '0;
               rsp_status_in    = status_ff;
               rsp_last_in      = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and result payload
   always_ff @(posedge clock) begin
      rounds_ff        <= rounds_in;
      status_ff        <= status_in;
      bx_ff            <= bx_in;
      by_ff            <= by_in;
      ex_ff            <= ex_in;
      ey_ff            <= ey_in;
      bc_ff            <= bc_in;
      ec_ff            <= ec_in;
      cc_ff            <= cc_in;
      onbeg_ff         <= onbeg_in;
      vphase_ff        <= vphase_in;
      edge_ff          <= edge_in;
      edgev_ff         <= edgev_in;
      mag_a_ff         <= mag_a_in;
      mag_b_ff         <= mag_b_in;
      mag_c_ff         <= mag_c_in;
      neg_ff           <= neg_in;
      prod_ff          <= mag_a_ff * mag_b_ff;
      rsp_has_point_ff <= rsp_has_point_in;
      rsp_edge_ff      <= rsp_edge_in;
      rsp_x_ff         <= rsp_x_in;
      rsp_y_ff         <= rsp_y_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_has_point = rsp_has_point_ff;
   assign rsp_edge_res  = rsp_edge_ff;
   assign rsp_point_x   = rsp_x_ff;
   assign rsp_point_y   = rsp_y_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

>>> hdl/line_rect_clip_crossings_core.sv
// Cohen-Sutherland segment clipper against a rectangle held in four CSRs.
// req_ channel: one segment per transaction (begin/end points, signed).
// rsp_ channel: one transaction per boundary crossing (has_point = 1, edge code,
// moved endpoint), then one status transaction with last = 1 (rejected,
// crosses, or wholly inside). At most 8 point transactions per segment.
// A segment with both points inside passes from the queue through the check
// and status states to the result register. Each edge move costs one
// multiply and one serial division of 2*COORD_WIDTH quotient bits plus
// sequencing; each round adds outcode checks, and the worst case is four
// rounds of two moves. The serial divider dominates the time per segment.
// A two-entry queue in front accepts segments while the engine works.
// A stalled rsp_ready holds the result register; the engine waits on it and
// the queue fills, then req_ready drops.
// Reset (synchronous) empties the queue, idles the engine and loads the
// rectangle 0..1023 on both axes. CSR writes take effect at once and must be
// made while no segment is in flight.
// Depends on lrcc_pkg, lrcc_front, lrcc_engine, lrcc_divider.
module line_rect_clip_crossings_core #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_begin_x,
   input  logic signed [COORD_WIDTH-1:0] req_begin_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_has_point,
   output lrcc_pkg::edge_type            rsp_edge_res,
   output logic signed [COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [COORD_WIDTH-1:0] rsp_point_y,
   output lrcc_pkg::status_type          rsp_status,
   output logic                          rsp_last,
   input  logic                          csr_write_en,
   input  lrcc_pkg::csr_index_type       csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_wdata
);
   import lrcc_pkg::*;

   // Upper reset bound, held to the largest coordinate for narrow builds
   localparam int RESET_HI = (COORD_WIDTH > 10) ? 1023 : (2 ** (COORD_WIDTH - 1)) - 1;

   logic signed [COORD_WIDTH-1:0] clip_left_ff, clip_top_ff, clip_right_ff, clip_bottom_ff;
   logic                          q_valid, q_pop;
   logic signed [COORD_WIDTH-1:0] q_bx, q_by, q_ex, q_ey;
   outcode_type                   q_bc, q_ec;

   // Rectangle registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_right_ff  <= COORD_WIDTH'(RESET_HI);
         clip_bottom_ff <= COORD_WIDTH'(RESET_HI);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CLIP_LEFT:   clip_left_ff   <= csr_wdata;
            CSR_CLIP_TOP:    clip_top_ff    <= csr_wdata;
            CSR_CLIP_RIGHT:  clip_right_ff  <= csr_wdata;
            CSR_CLIP_BOTTOM: clip_bottom_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   lrcc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_begin_x (req_begin_x),
      .req_begin_y (req_begin_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .clip_left   (clip_left_ff),
      .clip_top    (clip_top_ff),
      .clip_right  (clip_right_ff),
      .clip_bottom (clip_bottom_ff),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_bx        (q_bx),
      .q_by        (q_by),
      .q_ex        (q_ex),
      .q_ey        (q_ey),
      .q_bc        (q_bc),
      .q_ec        (q_ec)
   );

   lrcc_engine #(.COORD_WIDTH(COORD_WIDTH)) u_engine (
      .clock         (clock),
      .reset         (reset),
      .clip_left     (clip_left_ff),
      .clip_top      (clip_top_ff),
      .clip_right    (clip_right_ff),
      .clip_bottom   (clip_bottom_ff),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_bx          (q_bx),
      .q_by          (q_by),
      .q_ex          (q_ex),
      .q_ey          (q_ey),
      .q_bc          (q_bc),
      .q_ec          (q_ec),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_has_point (rsp_has_point),
      .rsp_edge_res  (rsp_edge_res),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule

>>> hdl/lrcc_checker.sv
// Port-level checker for the line clipper, bound to the top level.
// Depends on lrcc_pkg and line_rect_clip_crossings_core_macros.svh.
`include "line_rect_clip_crossings_core_macros.svh"

module lrcc_checker #(
   parameter int COORD_WIDTH = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_has_point,
   input lrcc_pkg::edge_type            rsp_edge_res,
   input logic signed [COORD_WIDTH-1:0] rsp_point_x,
   input logic signed [COORD_WIDTH-1:0] rsp_point_y,
   input lrcc_pkg::status_type          rsp_status,
   input logic                          rsp_last
);
   import lrcc_pkg::*;

   // Stalled result transaction holds
   `LRCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_point_x) && $stable(rsp_point_y) && $stable(rsp_last), "rsp changed while stalled")

   // Status transaction closes the segment and carries no point
   `LRCC_ASSERT_NOW(a_status_item, clock, reset, rsp_valid && !rsp_has_point, rsp_last && rsp_edge_res == EDGE_LEFT && rsp_point_x == '0 && rsp_point_y == '0, "bad status item")

   // Point transactions never close the segment
   `LRCC_ASSERT_NOW(a_point_item, clock, reset, rsp_valid && rsp_has_point, !rsp_last && rsp_status == STATUS_REJECT, "bad point item")

   // Nothing is presented right after reset
   `LRCC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "rsp valid after reset")

endmodule

bind line_rect_clip_crossings_core lrcc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (.*);
